[sv/b64d_pkg.sv]
// Shared types, character codes and the alphabet lookup of the base64url decoder.
// No dependencies; imported by the decoder core and its result buffer.

package b64d_pkg;

  // Final status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_TOO_SMALL = 2'd2
  } status_e;

  // Character codes of the URL-safe alphabet
  localparam logic [7:0] CH_UP_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_LO_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_DG_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DG_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_DASH = 8'h2D;  // '-'
  localparam logic [7:0] CH_USCR = 8'h5F;  // '_'
  localparam logic [7:0] CH_PAD  = 8'h3D;  // '='

  // Sextet values at the start of each alphabet range
  localparam logic [5:0] VAL_LO_BASE = 6'd26;
  localparam logic [5:0] VAL_DG_BASE = 6'd52;
  localparam logic [5:0] VAL_DASH    = 6'd62;
  localparam logic [5:0] VAL_USCR    = 6'd63;

  // Byte counter saturates here
  localparam logic [16:0] COUNT_CAP = 17'd65536;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } map_t;

  // One result item as held in the output queue
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_message;
    logic [1:0]  status;
    logic [15:0] bytes_written;
  } res_t;

  // Alphabet lookup; characters outside the alphabet map to zero, ok low
  function automatic map_t map_char(logic [7:0] c);
    map_t m;
    m.ok  = 1'b1;
    m.val = '0;
    priority if (c >= CH_UP_A && c <= CH_UP_Z) begin
      m.val = 6'(c - CH_UP_A);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      m.val = 6'(c - CH_LO_A) + VAL_LO_BASE;
    end else if (c >= CH_DG_0 && c <= CH_DG_9) begin
      m.val = 6'(c - CH_DG_0) + VAL_DG_BASE;
    end else if (c == CH_DASH) begin
      m.val = VAL_DASH;
    end else if (c == CH_USCR) begin
      m.val = VAL_USCR;
    end else begin
      m.ok = 1'b0;
    end
    return m;
  endfunction

endpackage

[sv/b64d_in_if.sv]
// Input channel of the base64url decoder: one character and a last mark per item.
// Valid/ready handshake; no dependencies.

interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

[sv/b64d_out_if.sv]
// Output channel of the base64url decoder: one decoded byte or final status per item.
// Valid/ready handshake; no dependencies.

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic [1:0]  status;
  logic [15:0] bytes_written;

  modport source (output valid, out_byte, byte_valid, end_of_message, status,
                  bytes_written, input ready);
  modport sink   (input valid, out_byte, byte_valid, end_of_message, status,
                  bytes_written, output ready);
endinterface

[sv/b64d_res_buf.sv]
// Three-entry result queue of the base64url decoder; loads a whole group of results
// at once; drains one item per cycle while out_o.ready. Uses b64d_pkg, b64d_out_if.

module b64d_res_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [1:0]        cnt_i,
  input  b64d_pkg::res_t    res_i [3],
  output logic              take_o,
  b64d_out_if.source        out_o
);
  import b64d_pkg::*;

  res_t       slot_q [3];
  res_t       slot_d [3];
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop    = (cnt_q != 2'd0) && out_o.ready;
  // A new group may load once the queue is empty after this cycle
  assign take_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);

  // Head of the queue drives the channel
  assign out_o.valid          = (cnt_q != 2'd0);
  assign out_o.out_byte       = slot_q[0].out_byte;
  assign out_o.byte_valid     = slot_q[0].byte_valid;
  assign out_o.end_of_message = slot_q[0].end_of_message;
  assign out_o.status         = slot_q[0].status;
  assign out_o.bytes_written  = slot_q[0].bytes_written;

  // Load or shift
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      slot_d = res_i;
      cnt_d  = cnt_i;
    end else if (pop) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

[sv/base64url_stream_decoder_core.sv]
// Top level of the streaming base64url decoder (URL-safe alphabet, optional padding).
// Depends on b64d_pkg, b64d_in_if, b64d_out_if and b64d_res_buf.
//
// Usage:
//   in_i carries one character per item with a last mark on the final character of a
//   message. out_o carries decoded bytes; the final item of a message has
//   end_of_message set and gives the status (ok, malformed, too small) and, when ok,
//   the byte count. Bytes of a message are only good if its status is ok.
//   cfg_we_i/cfg_data_i write the output capacity; write it only while idle.
// Timing:
//   The first result of an accepted character is offered in the cycle after acceptance.
//   Characters that yield zero or one result item are taken every cycle while out_o is
//   ready. A character that ends a group of four yields three bytes and holds off the
//   input until the last of them is being taken; so does a final character that
//   flushes two bytes. Output throughput is one item per cycle while out_o is ready.
// Reset:
//   Clears the message state and the queue; the capacity returns to 65535.
// Stall:
//   When out_o.ready is low the queue holds its items and in_i.ready drops as soon as
//   the queue cannot be emptied in the current cycle.

module base64url_stream_decoder_core #(
  parameter int MAX_CHARS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_in_if.sink     in_i,
  b64d_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);
  import b64d_pkg::*;

  localparam int UW = $clog2(MAX_CHARS + 1);

  // Message state
  logic [17:0]   acc_q, acc_d;
  logic [1:0]    pos_q, pos_d;
  logic [UW-1:0] unp_q, unp_d;
  logic          pad_seen_q, pad_seen_d;
  logic          pad_err_q, pad_err_d;
  logic          char_err_q, char_err_d;
  logic [16:0]   bcnt_q, bcnt_d;
  logic [15:0]   cap_q;

  logic          accept;
  logic          take;
  res_t          res [3];
  logic [1:0]    res_cnt;

  assign in_i.ready = take;
  assign accept     = in_i.valid && take;

  // Per-character decode: lookup, group assembly, tail flush and status
  always_comb begin
    map_t        m;
    logic        is_pad;
    logic [23:0] block;
    logic [7:0]  b [3];
    logic [1:0]  nb;
    logic [16:0] bsum;
    status_e     st;
    logic [1:0]  fin;

    m      = map_char(in_i.ch);
    is_pad = (in_i.ch == CH_PAD);
    block  = {acc_q, m.val};
    b[0]   = '0;
    b[1]   = '0;
    b[2]   = '0;
    nb     = 2'd0;
    st     = ST_OK;
    fin    = 2'd0;

    acc_d      = acc_q;
    pos_d      = pos_q;
    unp_d      = unp_q;
    pad_seen_d = pad_seen_q;
    pad_err_d  = pad_err_q;
    char_err_d = char_err_q;

    if (is_pad) begin
      pad_seen_d = 1'b1;
    end else begin
      if (pad_seen_q) pad_err_d = 1'b1;
      if (unp_q >= UW'(MAX_CHARS)) begin
        pad_err_d = 1'b1;
      end else begin
        unp_d = unp_q + UW'(1);
      end
      if (!m.ok) char_err_d = 1'b1;
      if (pos_q == 2'd3) begin
        b[0]  = block[23:16];
        b[1]  = block[15:8];
        b[2]  = block[7:0];
        nb    = 2'd3;
        acc_d = '0;
        pos_d = 2'd0;
      end else begin
        acc_d = {acc_q[11:0], m.val};
        pos_d = pos_q + 2'd1;
      end
    end

    // Tail flush on the last character
    if (in_i.last) begin
      if (pos_d == 2'd2) begin
        b[0] = acc_d[11:4];
        nb   = 2'd1;
      end else if (pos_d == 2'd3) begin
        b[0] = acc_d[17:10];
        b[1] = acc_d[9:2];
        nb   = 2'd2;
      end
    end

    // Saturating byte count
    bsum   = bcnt_q + 17'(nb);
    bcnt_d = (bsum > COUNT_CAP) ? COUNT_CAP : bsum;

    priority if (pad_err_d || pos_d == 2'd1) begin
      st = ST_MALFORMED;
    end else if (bcnt_d > {1'b0, cap_q}) begin
      st = ST_TOO_SMALL;
    end else if (char_err_d) begin
      st = ST_MALFORMED;
    end else begin
      st = ST_OK;
    end

    // Result items
    for (int k = 0; k < 3; k++) begin
      res[k].out_byte       = b[k];
      res[k].byte_valid     = (2'(k) < nb);
      res[k].end_of_message = 1'b0;
      res[k].status         = ST_OK;
      res[k].bytes_written  = '0;
    end
    res_cnt = nb;
    if (in_i.last) begin
      if (nb == 2'd0) begin
        res_cnt = 2'd1;
      end
      fin = res_cnt - 2'd1;
      res[fin].end_of_message = 1'b1;
      res[fin].status         = st;
      res[fin].bytes_written  = (st == ST_OK) ? bcnt_d[15:0] : 16'd0;
    end
  end

  // Message state; cleared after the final character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      pos_q      <= '0;
      unp_q      <= '0;
      pad_seen_q <= 1'b0;
      pad_err_q  <= 1'b0;
      char_err_q <= 1'b0;
      bcnt_q     <= '0;
    end else if (accept) begin
      if (in_i.last) begin
        acc_q      <= '0;
        pos_q      <= '0;
        unp_q      <= '0;
        pad_seen_q <= 1'b0;
        pad_err_q  <= 1'b0;
        char_err_q <= 1'b0;
        bcnt_q     <= '0;
      end else begin
        acc_q      <= acc_d;
        pos_q      <= pos_d;
        unp_q      <= unp_d;
        pad_seen_q <= pad_seen_d;
        pad_err_q  <= pad_err_d;
        char_err_q <= char_err_d;
        bcnt_q     <= bcnt_d;
      end
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  b64d_res_buf u_res_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .cnt_i  (res_cnt),
    .res_i  (res),
    .take_o (take),
    .out_o  (out_o)
  );

endmodule

[sim/tb_base64url_stream_decoder_core.sv]
// Testbench of base64url_stream_decoder_core: directed messages, then random messages under
// several idle/stall mixes, all checked against a cycle-free decoder predictor.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if and the decoder core.

module tb_base64url_stream_decoder_core;
  import b64d_pkg::*;

  // Short character limit so over-long messages are reachable in a short run
  localparam int CHAR_LIMIT = 16;
  localparam int DRAIN_CYC  = 8;
  localparam int PHASE_ITEMS = 12;

  typedef struct packed {
    logic        is_cfg;
    logic [15:0] cfg_val;
    logic [7:0]  ch;
    logic        is_last;
    logic        typed;     // final status and count given in the row
    status_e     want_st;
    logic [15:0] want_n;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64url_stream_decoder_core #(
    .MAX_CHARS(CHAR_LIMIT)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state of the message in flight
  logic [17:0] acc      = '0;
  logic [1:0]  gpos     = '0;
  int          char_cnt = 0;
  logic        pad_seen = 1'b0;
  logic        pad_err  = 1'b0;
  logic        char_err = 1'b0;
  int          nbytes   = 0;
  logic [15:0] capacity = 16'hFFFF;

  res_t     decoded_q[$];  // result items still due from the block
  dir_row_t dir_rows[$];
  int       mismatches = 0;
  int       idle_pct   = 0;
  int       stall_pct  = 0;
  int       hold_left  = 0;

  // Sextet value of a character, -1 outside the alphabet
  function automatic int sextet_of(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A);
    if (c >= CH_LO_A && c <= CH_LO_Z) return int'(c - CH_LO_A) + 26;
    if (c >= CH_DG_0 && c <= CH_DG_9) return int'(c - CH_DG_0) + 52;
    if (c == CH_DASH) return 62;
    if (c == CH_USCR) return 63;
    return -1;
  endfunction

  // Character that encodes a sextet value
  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return CH_UP_A + 8'(v);
    if (v < 52) return CH_LO_A + 8'(v - 26);
    if (v < 62) return CH_DG_0 + 8'(v - 52);
    if (v == 62) return CH_DASH;
    return CH_USCR;
  endfunction

  function automatic res_t byte_item(input logic [7:0] b);
    res_t r;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    if (nbytes < 65536) nbytes++;
    return r;
  endfunction

  // Decode one accepted character; queues its results, returns the final one (zero if not last)
  function automatic res_t decode_char(input logic [7:0] c, input logic is_last);
    res_t        step_q[$];
    res_t        tail;
    int          v;
    logic [23:0] grp;
    status_e     st;
    tail = '0;
    if (c == CH_PAD) begin
      pad_seen = 1'b1;
    end else begin
      v = sextet_of(c);
      if (pad_seen) pad_err = 1'b1;
      if (char_cnt >= CHAR_LIMIT) pad_err = 1'b1;
      else char_cnt++;
      if (v < 0) begin
        char_err = 1'b1;
        v = 0;
      end
      if (gpos == 2'd3) begin
        grp = {acc, 6'(v)};
        step_q.push_back(byte_item(grp[23:16]));
        step_q.push_back(byte_item(grp[15:8]));
        step_q.push_back(byte_item(grp[7:0]));
        acc  = '0;
        gpos = '0;
      end else begin
        acc  = {acc[11:0], 6'(v)};
        gpos = gpos + 2'd1;
      end
    end

    // End of message: flush the tail and attach the status to the last item
    if (is_last) begin
      if (gpos == 2'd2) begin
        step_q.push_back(byte_item(acc[11:4]));
      end else if (gpos == 2'd3) begin
        step_q.push_back(byte_item(acc[17:10]));
        step_q.push_back(byte_item(acc[9:2]));
      end
      if (pad_err || gpos == 2'd1) st = ST_MALFORMED;
      else if (nbytes > int'(capacity)) st = ST_TOO_SMALL;
      else if (char_err) st = ST_MALFORMED;
      else st = ST_OK;
      if (step_q.size() == 0) step_q.push_back('0);
      tail                = step_q.pop_back();
      tail.end_of_message = 1'b1;
      tail.status         = st;
      tail.bytes_written  = (st == ST_OK) ? nbytes[15:0] : 16'd0;
      step_q.push_back(tail);
      acc      = '0;
      gpos     = '0;
      char_cnt = 0;
      pad_seen = 1'b0;
      pad_err  = 1'b0;
      char_err = 1'b0;
      nbytes   = 0;
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
    return tail;
  endfunction

  function automatic void cmp(input string what, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result item with none due: byte %02h eom %0b", out_ch.out_byte,
                 out_ch.end_of_message);
      return;
    end
    want = decoded_q.pop_front();
    cmp("out_byte", want.out_byte, out_ch.out_byte);
    cmp("byte_valid", want.byte_valid, out_ch.byte_valid);
    cmp("end_of_message", want.end_of_message, out_ch.end_of_message);
    cmp("status", want.status, out_ch.status);
    cmp("bytes_written", want.bytes_written, out_ch.bytes_written);
  endfunction

  // Result side: random stalls plus a long hold-off when asked for
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one character, with random idle cycles first; valid stays high afterwards
  task automatic send_char(input logic [7:0] c, input logic is_last, output res_t fin);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.ch    <= c;
    in_ch.last  <= is_last;
    do @(posedge clk_i); while (!in_ch.ready);
    fin = decode_char(c, is_last);
  endtask

  // Pause the input until every due item has come, then let the block settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (decoded_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = v;
  endtask

  // Mostly clean messages with optional padding; some carry bad characters or inner pads
  task automatic send_random_msg(output int n);
    int         len;
    int         npad;
    int         pick;
    logic       noisy;
    logic [7:0] c;
    res_t       fin;
    noisy = ($urandom_range(0, 99) < 25);
    len   = $urandom_range(1, ($urandom_range(0, 9) == 0) ? CHAR_LIMIT + 4 : 10);
    npad  = ((len % 4) != 0 && $urandom_range(0, 1)) ? 4 - (len % 4) : 0;
    n     = len + npad;
    for (int i = 0; i < n; i++) begin
      c = sextet_char($urandom_range(0, 63));
      if (i >= len) begin
        c = CH_PAD;
      end else if (noisy) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) c = 8'($urandom_range(0, 255));
        else if (pick < 20) c = CH_PAD;
      end
      send_char(c, i == n - 1, fin);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [15:0] capv);
    int sent;
    int n;
    write_capacity(capv);
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < PHASE_ITEMS) begin
      send_random_msg(n);
      sent += n;
    end
  endtask

  function automatic void add_msg(input string s, input status_e st, input int n);
    dir_row_t r;
    for (int i = 0; i < s.len(); i++) begin
      r         = '0;
      r.ch      = s[i];
      r.is_last = (i == s.len() - 1);
      r.typed   = r.is_last;
      r.want_st = st;
      r.want_n  = 16'(n);
      dir_rows.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic is_cfg, input logic [15:0] v,
                                  input logic [7:0] c);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = is_cfg;
    r.cfg_val = v;
    r.ch      = c;
    dir_rows.push_back(r);
  endfunction

  // Main sequence
  initial begin
    res_t fin;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    in_ch.valid <= 1'b0;
    in_ch.ch    <= '0;
    in_ch.last  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed messages at reset capacity, then at capacity zero
    add_msg("QUJD", ST_OK, 3);          // one full group
    add_msg("-_8", ST_OK, 2);           // top of the alphabet, tail of three
    add_msg("A", ST_MALFORMED, 0);      // dangling single value
    add_msg("==", ST_OK, 0);            // padding only
    add_msg("Zm=9", ST_MALFORMED, 0);   // pad in the middle
    add_row(1'b0, '0, 8'h00);           // characters outside the alphabet
    add_row(1'b0, '0, 8'hFF);
    add_msg("z9", ST_MALFORMED, 0);
    add_row(1'b1, 16'h0000, '0);
    add_msg("AA", ST_TOO_SMALL, 0);     // one byte past capacity
    add_msg("QUJDA", ST_MALFORMED, 0);  // length check wins over capacity
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_capacity(dir_rows[i].cfg_val);
      end else begin
        send_char(dir_rows[i].ch, dir_rows[i].is_last, fin);
        if (dir_rows[i].typed) begin
          cmp("typed status", dir_rows[i].want_st, fin.status);
          cmp("typed bytes_written", dir_rows[i].want_n, fin.bytes_written);
        end
      end
    end

    // Random phases
    run_phase(0, 0, 16'd5);

    // Long hold-off on the result side while a long message keeps coming
    hold_left = 80;
    for (int i = 0; i < CHAR_LIMIT; i++)
      send_char(sextet_char($urandom_range(0, 63)), i == CHAR_LIMIT - 1, fin);

    run_phase(84, 0, 16'hFFFF);
    run_phase(0, 84, 16'($urandom_range(0, 65535)));
    run_phase(22, 22, 16'($urandom_range(0, 8)));

    wait_idle();
    if (decoded_q.size() != 0) begin
      mismatches++;
      $display("%0d result items never arrived", decoded_q.size());
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
